### design/mexp_pkg.sv
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Shared widths, defaults, register map and the control structs that pass
// between the sequencer and the shared modular reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

    // Field widths of the operand and result transactions.
    localparam int IN_WIDTH       = 63;
    localparam int RESULT_WIDTH   = 31;

    // Defaults for the top-level parameters.
    localparam int EXP_WIDTH_DEF  = 63;
    localparam int MOD_WIDTH_DEF  = 31;

    // The reduction unit always walks a 64-bit dividend, two bits a cycle.
    localparam int DIV_WIDTH      = 64;
    localparam int DIV_STEPS      = DIV_WIDTH / 2;

    // Configuration port.
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    // Register map, by word index (paddr[2]).
    localparam logic REG_MODULUS  = 1'b0;

    // Modulus after reset.
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;

    // Request from the sequencer to the reduction unit.
    typedef struct packed {
        logic                 start;
        logic [DIV_WIDTH-1:0] dividend;
    } red_req_t;

    // Status from the reduction unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } red_rsp_t;

endpackage

`default_nettype wire

### design/mexp_in_if.sv
// ----------------------------------------------------------------------------
// Operand channel
// Valid/ready channel that carries one base and one exponent per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();

    logic                valid;
    logic                ready;
    logic [IN_WIDTH-1:0] base_value;
    logic [IN_WIDTH-1:0] exponent;

    modport source (output valid, output base_value, output exponent, input ready);
    modport sink   (input valid, input base_value, input exponent, output ready);

endinterface

`default_nettype wire

### design/mexp_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one modular power per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mexp_out_if import mexp_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [RESULT_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);

endinterface

`default_nettype wire

### design/mexp_cfg.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave that holds the modulus register.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_cfg import mexp_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready,
    output logic      [MOD_WIDTH-1:0]      modulus
);

    logic [MOD_WIDTH-1:0] modulus_reg;
    logic                 hit;

    // Word decode; byte offsets within the word are not decoded.
    assign hit = (paddr[2] == REG_MODULUS);

    // Register write in the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_WIDTH'(MODULUS_RESET);
        end
        else if (psel && penable && pwrite && hit)
        begin
            modulus_reg <= pwdata[MOD_WIDTH-1:0];
        end
    end

    // Read data and a slave that never inserts wait states.
    assign prdata  = hit ? APB_DATA_WIDTH'(modulus_reg) : '0;
    assign pready  = 1'b1;
    assign modulus = modulus_reg;

endmodule

`default_nettype wire

### design/mexp_modred.sv
// ----------------------------------------------------------------------------
// Modular reduction unit
// Restoring remainder of a 64-bit dividend by the modulus, two dividend bits
// per cycle, shared by the base reduction, the multiplies and the squarings.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modred import mexp_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire red_req_t             req,
    input  wire logic [MOD_WIDTH-1:0] modulus,
    output red_rsp_t                  rsp,
    output logic      [MOD_WIDTH-1:0] remainder
);

    localparam int CNT_WIDTH = $clog2(DIV_STEPS);

    logic                 busy_reg,  busy_next;
    logic                 done_reg,  done_next;
    logic [CNT_WIDTH-1:0] cnt_reg,   cnt_next;
    logic [DIV_WIDTH-1:0] shift_reg, shift_next;
    logic [MOD_WIDTH-1:0] rem_reg,   rem_next;
    logic [MOD_WIDTH-1:0] rem_mid;

    // One restoring step: shift in a bit, subtract the modulus if it fits.
    // The partial remainder stays below the modulus, so one subtract is enough.
    function automatic logic [MOD_WIDTH-1:0] rem_step(
        input logic [MOD_WIDTH-1:0] r,
        input logic                 bit_in,
        input logic [MOD_WIDTH-1:0] m
    );
        logic [MOD_WIDTH:0] t;
        t = {r, bit_in};
        if (t >= {1'b0, m})
        begin
            t = t - {1'b0, m};
        end
        return t[MOD_WIDTH-1:0];
    endfunction

    // Two dependent steps per cycle.
    assign rem_mid = rem_step(rem_reg, shift_reg[DIV_WIDTH-1], modulus);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_WIDTH'(DIV_STEPS - 1);
            shift_next = req.dividend;
            rem_next   = '0;
        end
        else if (busy_reg)
        begin
            rem_next   = rem_step(rem_mid, shift_reg[DIV_WIDTH-2], modulus);
            shift_next = shift_reg << 2;
            cnt_next   = cnt_reg - CNT_WIDTH'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign rsp.busy  = busy_reg;
    assign rsp.done  = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

### design/mexp_seq.sv
// ----------------------------------------------------------------------------
// Square-and-multiply sequencer
// Scans the exponent from its least significant bit, forms each product on
// one multiplier and hands it to the shared reduction unit.
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_seq import mexp_pkg::*; #(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [MOD_WIDTH-1:0] modulus,
    mexp_in_if.sink                   operands,
    mexp_out_if.source                result,
    output red_req_t                  red_req,
    output logic      [MOD_WIDTH-1:0] red_modulus,
    input  wire red_rsp_t             red_rsp,
    input  wire logic [MOD_WIDTH-1:0] red_remainder
);

    localparam int PROD_WIDTH = 2 * MOD_WIDTH;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_STEP,
        ST_LOAD_ACC,
        ST_WAIT_ACC,
        ST_SQ_PREP,
        ST_LOAD_SQ,
        ST_WAIT_SQ,
        ST_FINISH
    } state_t;

    state_t                state_reg,  state_next;
    logic [MOD_WIDTH-1:0]  m_reg,      m_next;
    logic [EXP_WIDTH-1:0]  e_reg,      e_next;
    logic [MOD_WIDTH-1:0]  acc_reg,    acc_next;
    logic [MOD_WIDTH-1:0]  b_reg,      b_next;
    logic [PROD_WIDTH-1:0] prod_reg,   prod_next;
    logic                  valid_reg,  valid_next;
    logic [MOD_WIDTH-1:0]  out_reg,    out_next;
    logic [MOD_WIDTH-1:0]  mul_a;
    logic [PROD_WIDTH-1:0] product;
    logic [EXP_WIDTH-1:0]  e_shift;
    logic                  accept;

    assign accept  = operands.valid && operands.ready;
    assign e_shift = e_reg >> 1;

    // The one multiplier: result times base in STEP, base squared otherwise.
    assign mul_a   = (state_reg == ST_STEP) ? acc_reg : b_reg;
    assign product = PROD_WIDTH'(mul_a) * PROD_WIDTH'(b_reg);

    // Requests to the reduction unit: the raw base first, then products.
    always_comb
    begin
        red_req.start    = accept || (state_reg == ST_LOAD_ACC) || (state_reg == ST_LOAD_SQ);
        red_req.dividend = (state_reg == ST_IDLE) ? DIV_WIDTH'(operands.base_value)
                                                  : DIV_WIDTH'(prod_reg);
    end

    // Next-state and datapath decisions.
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        e_next     = e_reg;
        acc_next   = acc_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        out_next   = out_reg;
        valid_next = valid_reg;
        if (valid_reg && result.ready)
        begin
            valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // A zero modulus behaves as a modulus of one.
                    m_next     = (modulus == '0) ? MOD_WIDTH'(1) : modulus;
                    e_next     = operands.exponent[EXP_WIDTH-1:0];
                    acc_next   = MOD_WIDTH'(1);
                    state_next = ST_RED_BASE;
                end
            end
            ST_RED_BASE:
            begin
                if (red_rsp.done)
                begin
                    b_next     = red_remainder;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (e_reg == '0)
                begin
                    state_next = ST_FINISH;
                end
                else if (e_reg[0])
                begin
                    prod_next  = product;
                    state_next = ST_LOAD_ACC;
                end
                else
                begin
                    state_next = ST_SQ_PREP;
                end
            end
            ST_LOAD_ACC:
            begin
                state_next = ST_WAIT_ACC;
            end
            ST_WAIT_ACC:
            begin
                if (red_rsp.done)
                begin
                    acc_next   = red_remainder;
                    state_next = ST_SQ_PREP;
                end
            end
            ST_SQ_PREP:
            begin
                // The square after the top set bit cannot change the result.
                if (e_shift == '0)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    prod_next  = product;
                    state_next = ST_LOAD_SQ;
                end
            end
            ST_LOAD_SQ:
            begin
                state_next = ST_WAIT_SQ;
            end
            ST_WAIT_SQ:
            begin
                if (red_rsp.done)
                begin
                    b_next     = red_remainder;
                    e_next     = e_shift;
                    state_next = ST_STEP;
                end
            end
            ST_FINISH:
            begin
                // Wait until the output register is free.
                if (!valid_reg || result.ready)
                begin
                    out_next   = acc_reg;
                    valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        e_reg    <= e_next;
        acc_reg  <= acc_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign operands.ready      = (state_reg == ST_IDLE);
    assign result.valid        = valid_reg;
    assign result.power_result = RESULT_WIDTH'(out_reg);
    assign red_modulus         = (state_reg == ST_IDLE) ? MOD_WIDTH'(1) : m_reg;

endmodule

`default_nettype wire

### design/modular_exponentiation.sv
// ----------------------------------------------------------------------------
// Modular exponentiation
// Raises a base to an exponent modulo a configured modulus by right-to-left
// square-and-multiply on one shared multiplier and reduction unit.
// ----------------------------------------------------------------------------
// Usage:
//   Operands arrive on a valid/ready channel as one transaction holding
//   base_value and exponent; each yields one power_result transaction on the
//   result channel. The modulus is written over the APB port at address 0;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce. A zero modulus acts as a modulus of one.
//   Each job first reduces the base. Each multiply or square forms the
//   product, starts the reduction unit and then takes its remainder. An
//   exponent bit below the top set bit costs a decision plus a square when
//   clear and a decision, a multiply and a square when set; the top set bit
//   costs a decision and a multiply, then the square check and the finish.
//   A zero exponent still waits for the base reduction and returns 1. The
//   reduction unit, which retires two dividend bits per cycle, sets the rate.
//   Operands are taken only while the sequencer is idle; a finished result
//   sits in the output register, and the next transaction may be accepted
//   while it waits. A stalled receiver holds the result and holds the
//   following transaction in its final cycle until the register is free.
//   Reset clears the sequencer and the result valid and loads the modulus
//   with 1000000007.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_exponentiation import mexp_pkg::*; #(
    parameter int EXP_WIDTH = EXP_WIDTH_DEF,
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic      [APB_DATA_WIDTH-1:0] prdata,
    output logic                           pready,
    mexp_in_if.sink                        operands,
    mexp_out_if.source                     result
);

    logic [MOD_WIDTH-1:0] modulus;
    logic [MOD_WIDTH-1:0] red_modulus;
    logic [MOD_WIDTH-1:0] red_remainder;
    red_req_t             red_req;
    red_rsp_t             red_rsp;

    // Configuration registers.
    mexp_cfg #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .modulus (modulus)
    );

    // Square-and-multiply sequencer.
    mexp_seq #(
        .EXP_WIDTH (EXP_WIDTH),
        .MOD_WIDTH (MOD_WIDTH)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus       (modulus),
        .operands      (operands),
        .result        (result),
        .red_req       (red_req),
        .red_modulus   (red_modulus),
        .red_rsp       (red_rsp),
        .red_remainder (red_remainder)
    );

    // Shared reduction unit.
    mexp_modred #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_modred (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (red_req),
        .modulus   (red_modulus),
        .rsp       (red_rsp),
        .remainder (red_remainder)
    );

`ifndef NO_ASSERTIONS
    // The sequencer never restarts the reduction unit in the middle of a job.
    assert property (@(posedge clk) disable iff (!rst_n)
        red_req.start |-> !red_rsp.busy)
        else $error("reduction started while busy");

    // Every finished reduction lies below the modulus it used.
    assert property (@(posedge clk) disable iff (!rst_n)
        red_rsp.done |-> (red_remainder < red_modulus))
        else $error("remainder not below modulus");

    // After taking operands the block stays closed in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        operands.valid && operands.ready |=> !operands.ready)
        else $error("operands accepted on consecutive cycles");
`endif

endmodule

`default_nettype wire
